FILE: rtl/core/bcast_pkg.sv
package bcast_pkg;

	localparam int EXT_W           = 12;
	localparam int SHAPE_W         = 48;
	localparam int CFG_W           = 48;
	localparam int EPS_W           = 16;
	localparam int DATA_W          = 32;
	localparam int DEF_MAX_DIMS    = 4;
	localparam int DEF_STORE_DEPTH = 4096;
	localparam int DEF_FRAC_BITS   = 16;

	localparam logic [1:0] KIND_WR_FIRST  = 2'd0;
	localparam logic [1:0] KIND_WR_SECOND = 2'd1;
	localparam logic [1:0] KIND_COMPUTE   = 2'd2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_BCAST = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_DIV_ZERO = 2'd3;

	localparam logic [1:0] REG_FIRST_SHAPE  = 2'd0;
	localparam logic [1:0] REG_SECOND_SHAPE = 2'd1;
	localparam logic [1:0] REG_OP_MODE      = 2'd2;
	localparam logic [1:0] REG_EPSILON      = 2'd3;

endpackage

FILE: rtl/core/bcast_coord.sv
module bcast_coord #(
	parameter int MAX_DIMS = bcast_pkg::DEF_MAX_DIMS,
	parameter int SW       = 1
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      en,
	input  logic                                      in_valid,
	input  logic [bcast_pkg::EXT_W-1:0]               idx,
	input  logic [MAX_DIMS-1:0][bcast_pkg::EXT_W-1:0] ext,
	input  logic [SW-1:0]                             side_in,
	output logic                                      out_valid,
	output logic [MAX_DIMS-1:0][bcast_pkg::EXT_W-1:0] coord,
	output logic                                      quot_zero,
	output logic [SW-1:0]                             side_out
);
	import bcast_pkg::*;

	localparam int NS = MAX_DIMS * EXT_W;

	logic                              v_p   [NS+1];
	logic [EXT_W-1:0]                  dvd_p [NS+1];
	logic [EXT_W-1:0]                  rem_p [NS+1];
	logic [EXT_W-1:0]                  q_p   [NS+1];
	logic [MAX_DIMS-1:0][EXT_W-1:0]    crd_p [NS+1];
	logic [SW-1:0]                     side_p[NS+1];

	// dividend of the first dimension enters through the quotient slot
	assign v_p[0]    = in_valid;
	assign dvd_p[0]  = '0;
	assign rem_p[0]  = '0;
	assign q_p[0]    = idx;
	assign crd_p[0]  = '0;
	assign side_p[0] = side_in;

	for (genvar s = 0; s < NS; s++) begin : g_step
		localparam int D = s / EXT_W;
		localparam int J = s % EXT_W;

		logic [EXT_W-1:0] dvd, rem_i, q_i, rem_n, q_n;
		logic [EXT_W:0]   t;
		logic             ge;
		logic [MAX_DIMS-1:0][EXT_W-1:0] crd_n;

		// one quotient bit per stage, restoring
		always_comb begin
			dvd   = (J == 0) ? q_p[s] : dvd_p[s];
			rem_i = (J == 0) ? '0 : rem_p[s];
			q_i   = (J == 0) ? '0 : q_p[s];
			t     = {rem_i, dvd[EXT_W-1-J]};
			ge    = t >= {1'b0, ext[D]};
			rem_n = ge ? EXT_W'(t - {1'b0, ext[D]}) : t[EXT_W-1:0];
			q_n   = q_i;
			q_n[EXT_W-1-J] = ge;
			crd_n = crd_p[s];
			if (J == EXT_W - 1) begin
				crd_n[D] = rem_n;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[s+1] <= 1'b0;
			end else if (en) begin
				v_p[s+1] <= v_p[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_p[s+1]  <= dvd;
				rem_p[s+1]  <= rem_n;
				q_p[s+1]    <= q_n;
				side_p[s+1] <= side_p[s];
				crd_p[s+1]  <= crd_n;
			end
		end
	end

	assign out_valid = v_p[NS];
	assign coord     = crd_p[NS];
	assign quot_zero = (q_p[NS] == '0);
	assign side_out  = side_p[NS];

endmodule

FILE: rtl/core/bcast_div.sv
module bcast_div #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quot,
	output logic [SW-1:0] side_out
);
	logic          v_p   [NW+1];
	logic [NW-1:0] n_p   [NW+1];
	logic [DW-1:0] rem_p [NW+1];
	logic [DW-1:0] den_p [NW+1];
	logic [SW-1:0] side_p[NW+1];

	assign v_p[0]    = in_valid;
	assign n_p[0]    = num;
	assign rem_p[0]  = '0;
	assign den_p[0]  = den;
	assign side_p[0] = side_in;

	// numerator shifts out on top, quotient bits shift in below
	for (genvar s = 0; s < NW; s++) begin : g_step
		logic [DW:0]   t;
		logic          ge;
		logic [DW-1:0] rem_n;

		always_comb begin
			t     = {rem_p[s], n_p[s][NW-1]};
			ge    = t >= {1'b0, den_p[s]};
			rem_n = ge ? DW'(t - {1'b0, den_p[s]}) : t[DW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_p[s+1] <= 1'b0;
			end else if (en) begin
				v_p[s+1] <= v_p[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_p[s+1]    <= {n_p[s][NW-2:0], ge};
				rem_p[s+1]  <= rem_n;
				den_p[s+1]  <= den_p[s];
				side_p[s+1] <= side_p[s];
			end
		end
	end

	assign out_valid = v_p[NW];
	assign quot      = n_p[NW];
	assign side_out  = side_p[NW];

endmodule

FILE: rtl/core/broadcast_elementwise_binary_op.sv
// broadcasting element-wise binary op on two stored tensors. write beats
// (tuser kind 0 or 1) load an element of the first or second operand at
// the given address; a compute beat (kind 2) names an output linear index
// and returns one beat with the combined q16.16 element and a status code.
// shapes are four 12-bit extents each, innermost lowest. one beat enters
// every cycle; every beat passes through the bit-per-stage coordinate
// split and every compute beat through the bit-per-stage divider, so
// that results stay in order. writes are
// applied at the memory stage in beat order. a stall on the output holds
// the whole pipe. STORE_DEPTH is taken as a power of two. after a shape
// write, each stride register settles after the one for the dimension below.
module broadcast_elementwise_binary_op #(
	parameter int MAX_DIMS    = bcast_pkg::DEF_MAX_DIMS,
	parameter int STORE_DEPTH = bcast_pkg::DEF_STORE_DEPTH,
	parameter int FRAC_BITS   = bcast_pkg::DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write port
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [bcast_pkg::CFG_W-1:0] cfg_data,
	// input beats
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [47:0]                 s_axis_tdata,  // index[11:0], value[43:12], zero fill
	input  logic [1:0]                  s_axis_tuser,  // kind[1:0]
	// result beats
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata,  // result[31:0]
	output logic [1:0]                  m_axis_tuser   // status[1:0]
);
	import bcast_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int NW = DATA_W + FRAC_BITS;

	localparam logic signed [63:0] HALF  = (64'sd1 <<< FRAC_BITS) >>> 1;
	localparam logic signed [63:0] S_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S_MIN = -64'sd2147483648;
	localparam logic [DATA_W-1:0]  R_MAX = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0]  R_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [1:0]        kind;
		logic [EXT_W-1:0]  idx;
		logic [DATA_W-1:0] value;
	} pre_t;

	typedef struct packed {
		logic [DATA_W-1:0] res;
		logic [1:0]        status;
		logic              is_div;
		logic              neg;
		logic              dz;
		logic              apos;
		logic              aneg;
	} post_t;

	// global advance: the whole pipe moves unless the output beat is stuck
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// configuration registers
	logic [SHAPE_W-1:0] first_shape_q, second_shape_q;
	logic [1:0]         op_q;
	logic [EPS_W-1:0]   eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_shape_q  <= 48'h001_001_001_001;
			second_shape_q <= 48'h001_001_001_001;
			op_q           <= OP_ADD;
			eps_q          <= 16'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FIRST_SHAPE:  first_shape_q  <= cfg_data[SHAPE_W-1:0];
				REG_SECOND_SHAPE: second_shape_q <= cfg_data[SHAPE_W-1:0];
				REG_OP_MODE:      op_q           <= cfg_data[1:0];
				REG_EPSILON:      eps_q          <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// extents, broadcast extents and shape checks
	logic [MAX_DIMS-1:0][EXT_W-1:0] ra, rb, rr;
	logic [MAX_DIMS-1:0]            bad_d, zero_d;
	logic                           bc_bad, rr_zero;

	always_comb begin
		for (int d = 0; d < MAX_DIMS; d++) begin
			ra[d]     = first_shape_q[EXT_W*d +: EXT_W];
			rb[d]     = second_shape_q[EXT_W*d +: EXT_W];
			rr[d]     = (ra[d] == rb[d] || rb[d] == EXT_W'(1)) ? ra[d] : rb[d];
			bad_d[d]  = !(ra[d] == rb[d] || rb[d] == EXT_W'(1) || ra[d] == EXT_W'(1));
			zero_d[d] = (rr[d] == '0);
		end
		bc_bad  = |bad_d;
		rr_zero = |zero_d;
	end

	// per-dimension strides, modulo the store depth
	logic [MAX_DIMS-1:0][AW-1:0] ja_q, jb_q;

	for (genvar d = 0; d < MAX_DIMS; d++) begin : g_jump
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ja_q[d] <= AW'(1);
				jb_q[d] <= AW'(1);
			end else if (d == 0) begin
				ja_q[d] <= AW'(1);
				jb_q[d] <= AW'(1);
			end else begin
				ja_q[d] <= AW'(ja_q[(d == 0) ? 0 : d-1] * ra[(d == 0) ? 0 : d-1][AW-1:0]);
				jb_q[d] <= AW'(jb_q[(d == 0) ? 0 : d-1] * rb[(d == 0) ? 0 : d-1][AW-1:0]);
			end
		end
	end

	// split the output index into coordinates
	pre_t                           pre_in, pre_c;
	logic                           v_c, qz_c;
	logic [MAX_DIMS-1:0][EXT_W-1:0] crd_c;

	assign pre_in.kind  = s_axis_tuser;
	assign pre_in.idx   = s_axis_tdata[11:0];
	assign pre_in.value = s_axis_tdata[43:12];

	bcast_coord #(
		.MAX_DIMS (MAX_DIMS),
		.SW       ($bits(pre_t))
	) u_coord (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.idx       (s_axis_tdata[11:0]),
		.ext       (rr),
		.side_in   (pre_in),
		.out_valid (v_c),
		.coord     (crd_c),
		.quot_zero (qz_c),
		.side_out  (pre_c)
	);

	// m1: coordinate times stride per operand
	logic                        v_m1, range_m1;
	pre_t                        pre_m1;
	logic [MAX_DIMS-1:0][AW-1:0] pa_m1, pb_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
		end else if (en) begin
			v_m1 <= v_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_m1   <= pre_c;
			range_m1 <= rr_zero || !qz_c;
			for (int d = 0; d < MAX_DIMS; d++) begin
				// an extent of one pins that coordinate to zero
				pa_m1[d] <= (ra[d] == EXT_W'(1)) ? '0 : AW'(crd_c[d][AW-1:0] * ja_q[d]);
				pb_m1[d] <= (rb[d] == EXT_W'(1)) ? '0 : AW'(crd_c[d][AW-1:0] * jb_q[d]);
			end
		end
	end

	// m2: source addresses
	logic [AW-1:0] sa, sb;
	always_comb begin
		sa = '0;
		sb = '0;
		for (int d = 0; d < MAX_DIMS; d++) begin
			sa = AW'(sa + pa_m1[d]);
			sb = AW'(sb + pb_m1[d]);
		end
	end

	logic          v_m2, range_m2;
	pre_t          pre_m2;
	logic [AW-1:0] addr_a_m2, addr_b_m2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m2 <= 1'b0;
		end else if (en) begin
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_m2    <= pre_m1;
			range_m2  <= range_m1;
			addr_a_m2 <= sa;
			addr_b_m2 <= sb;
		end
	end

	// m3: element memories, writes land here in beat order
	logic [DATA_W-1:0] mem_a [STORE_DEPTH];
	logic [DATA_W-1:0] mem_b [STORE_DEPTH];
	logic [DATA_W-1:0] a_m3, b_m3;
	logic              v_m3;
	logic [1:0]        st_m3;

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_m2 && pre_m2.kind == KIND_WR_FIRST) begin
				mem_a[pre_m2.idx[AW-1:0]] <= pre_m2.value;
			end
			a_m3 <= mem_a[addr_a_m2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_m2 && pre_m2.kind == KIND_WR_SECOND) begin
				mem_b[pre_m2.idx[AW-1:0]] <= pre_m2.value;
			end
			b_m3 <= mem_b[addr_b_m2];
		end
	end

	// only compute beats go on from here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m3 <= 1'b0;
		end else if (en) begin
			v_m3 <= v_m2 && pre_m2.kind == KIND_COMPUTE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_m3 <= bc_bad ? ST_NO_BCAST : (range_m2 ? ST_RANGE : ST_OK);
		end
	end

	// o1: sum, product, divider operands
	logic signed [DATA_W-1:0] a_sv, b_sv;
	logic signed [33:0]       div_sum;
	logic [DATA_W-1:0]        abs_a;

	assign a_sv    = a_m3;
	assign b_sv    = b_m3;
	assign div_sum = 34'(b_sv) + $signed({18'd0, eps_q});
	assign abs_a   = a_sv[DATA_W-1] ? DATA_W'(-a_sv) : a_m3;

	logic                     v_o1, neg_o1, dz_o1, apos_o1, aneg_o1;
	logic [1:0]               st_o1, op_o1;
	logic signed [32:0]       sum_o1;
	logic signed [63:0]       prod_o1;
	logic [NW-1:0]            num_o1;
	logic [DATA_W-1:0]        den_o1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o1 <= 1'b0;
		end else if (en) begin
			v_o1 <= v_m3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_o1   <= st_m3;
			op_o1   <= op_q;
			sum_o1  <= (op_q == OP_SUB) ? 33'(a_sv) - 33'(b_sv) : 33'(a_sv) + 33'(b_sv);
			prod_o1 <= 64'(a_sv) * 64'(b_sv);
			num_o1  <= NW'(abs_a) << FRAC_BITS;
			den_o1  <= div_sum[33] ? DATA_W'(-div_sum) : div_sum[DATA_W-1:0];
			neg_o1  <= a_sv[DATA_W-1] ^ div_sum[33];
			dz_o1   <= (div_sum == '0);
			apos_o1 <= !a_sv[DATA_W-1] && (a_m3 != '0);
			aneg_o1 <= a_sv[DATA_W-1];
		end
	end

	// o2: saturate add, sub and rounded multiply
	logic signed [63:0] prod_r;
	logic [DATA_W-1:0]  res_n;

	always_comb begin
		prod_r = (prod_o1 + HALF) >>> FRAC_BITS;
		res_n  = '0;
		case (op_o1)
			OP_ADD, OP_SUB: begin
				if (sum_o1[32] != sum_o1[31]) begin
					res_n = sum_o1[32] ? R_MIN : R_MAX;
				end else begin
					res_n = sum_o1[DATA_W-1:0];
				end
			end
			OP_MUL: begin
				if (prod_r > S_MAX) begin
					res_n = R_MAX;
				end else if (prod_r < S_MIN) begin
					res_n = R_MIN;
				end else begin
					res_n = prod_r[DATA_W-1:0];
				end
			end
			default: res_n = '0;
		endcase
	end

	logic              v_o2;
	post_t             post_o2;
	logic [NW-1:0]     num_o2;
	logic [DATA_W-1:0] den_o2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o2 <= 1'b0;
		end else if (en) begin
			v_o2 <= v_o1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			post_o2.res    <= res_n;
			post_o2.status <= st_o1;
			post_o2.is_div <= (op_o1 == OP_DIV);
			post_o2.neg    <= neg_o1;
			post_o2.dz     <= dz_o1;
			post_o2.apos   <= apos_o1;
			post_o2.aneg   <= aneg_o1;
			num_o2         <= num_o1;
			den_o2         <= den_o1;
		end
	end

	// magnitude divider, one quotient bit per stage
	logic          v_d;
	logic [NW-1:0] q_d;
	post_t         post_d;

	bcast_div #(
		.NW (NW),
		.DW (DATA_W),
		.SW ($bits(post_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_o2),
		.num       (num_o2),
		.den       (den_o2),
		.side_in   (post_o2),
		.out_valid (v_d),
		.quot      (q_d),
		.side_out  (post_d)
	);

	// final select: status first, then divide-by-zero, then the quotient or the o2 result
	logic [DATA_W-1:0] res_f;
	logic [1:0]        st_f;

	always_comb begin
		res_f = post_d.res;
		st_f  = post_d.status;
		if (post_d.status != ST_OK) begin
			res_f = '0;
		end else if (post_d.is_div && post_d.dz) begin
			st_f  = ST_DIV_ZERO;
			res_f = post_d.apos ? R_MAX : (post_d.aneg ? R_MIN : '0);
		end else if (post_d.is_div) begin
			if (!post_d.neg) begin
				res_f = (q_d > NW'(64'd2147483647)) ? R_MAX : q_d[DATA_W-1:0];
			end else begin
				res_f = (q_d > NW'(64'd2147483648)) ? R_MIN : DATA_W'(-q_d[DATA_W-1:0]);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= res_f;
			m_axis_tuser <= st_f;
		end
	end

endmodule
